// ===== sv/command_field_parser_macros.svh =====
// assertion macros shared by the command field parser modules
`ifndef COMMAND_FIELD_PARSER_MACROS_SVH
`define COMMAND_FIELD_PARSER_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define CFP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define CFP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cfp_pkg.sv =====
// types and constants of the command field parser
`timescale 1ns / 1ps
package cfp_pkg;

  // character codes
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharDel    = 8'h7F;
  localparam logic [7:0] CtrlLimit  = 8'h20;
  localparam logic [7:0] DelimReset = 8'h2C;
  localparam logic [7:0] IndexMax   = 8'hFF;

  // configuration register indexes
  localparam logic RegDelimiter = 1'b0;
  localparam logic RegReaderEn  = 1'b1;

  localparam int unsigned NameCntW = 4;
  localparam int unsigned TdataOutW = 112;

  typedef struct packed {
    logic [7:0] delimiter_char;
    logic       reader_enabled;
  } cfg_t;

  typedef struct packed {
    logic [63:0]        name_chars;
    logic [3:0]         name_length;
    logic               name_truncated;
    logic [7:0]         field_index;
    logic signed [31:0] field_value;
  } record_t;

endpackage

// ===== sv/cfp_in_stage.sv =====
// input register holding one received byte
`timescale 1ns / 1ps
module cfp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       advance_i,
  output logic       byte_valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  // free when empty or when the held word moves on this cycle
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

endmodule

// ===== sv/cfp_parser.sv =====
// line parser state and per-byte update
`timescale 1ns / 1ps
`include "command_field_parser_macros.svh"
module cfp_parser #(
  parameter int unsigned MAX_NAME = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfp_pkg::cfg_t   cfg_i,
  input  logic            step_i,
  input  logic [7:0]      byte_i,
  output logic            rec_valid_o,
  output cfp_pkg::record_t rec_o
);

  localparam logic [cfp_pkg::NameCntW-1:0] NameMax = cfp_pkg::NameCntW'(MAX_NAME);

  logic [63:0]                 name_q, name_d;
  logic [cfp_pkg::NameCntW-1:0] cnt_q, cnt_d;
  logic                        ovf_q, ovf_d;
  logic [7:0]                  dcnt_q, dcnt_d;
  logic [31:0]                 acc_q, acc_d;
  logic                        neg_q, neg_d;

  logic is_digit, is_minus, is_delim, is_ctrl, has_field, ends_field;
  logic [31:0] digit;

  // byte classification
  assign is_digit  = (byte_i >= cfp_pkg::CharZero) && (byte_i <= cfp_pkg::CharNine);
  assign is_minus  = (byte_i == cfp_pkg::CharMinus);
  assign is_delim  = (byte_i == cfg_i.delimiter_char);
  assign is_ctrl   = (byte_i < cfp_pkg::CtrlLimit) || (byte_i == cfp_pkg::CharDel);
  assign has_field = (dcnt_q != 8'd0);
  assign digit     = {24'd0, byte_i - cfp_pkg::CharZero};

  // digits and sign take precedence over the delimiter once in a value field
  assign ends_field = !(has_field && (is_digit || is_minus)) && (is_delim || is_ctrl);

  // record from the state before this byte
  assign rec_valid_o = step_i && ends_field && cfg_i.reader_enabled && (cnt_q != '0);
  always_comb begin
    rec_o.name_chars     = name_q;
    rec_o.name_length    = cnt_q;
    rec_o.name_truncated = ovf_q;
    rec_o.field_index    = dcnt_q;
    rec_o.field_value    = neg_q ? -$signed(acc_q) : $signed(acc_q);
  end

  // next state
  always_comb begin
    name_d = name_q;
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    dcnt_d = dcnt_q;
    acc_d  = acc_q;
    neg_d  = neg_q;
    if (step_i) begin
      if (has_field && is_digit) begin
        acc_d = (acc_q << 3) + (acc_q << 1) + digit;
      end else if (has_field && is_minus) begin
        neg_d = !neg_q;
      end else if (is_delim || is_ctrl) begin
        acc_d = 32'd0;
        neg_d = 1'b0;
      end else if (!has_field) begin
        if (cnt_q < NameMax) begin
          name_d = name_q | ({56'd0, byte_i} << {cnt_q[2:0], 3'b000});
          cnt_d  = cnt_q + 1'b1;
        end else begin
          ovf_d = 1'b1;
        end
      end
      if (is_delim && (dcnt_q != cfp_pkg::IndexMax)) begin
        dcnt_d = dcnt_q + 8'd1;
      end
      // control byte ends the line
      if (is_ctrl) begin
        name_d = 64'd0;
        cnt_d  = '0;
        ovf_d  = 1'b0;
        dcnt_d = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_q <= 64'd0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      dcnt_q <= 8'd0;
      acc_q  <= 32'd0;
      neg_q  <= 1'b0;
    end else begin
      name_q <= name_d;
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
      dcnt_q <= dcnt_d;
      acc_q  <= acc_d;
      neg_q  <= neg_d;
    end
  end

  `CFP_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= NameMax, "name count above limit")
  `CFP_ASSERT_IMP(a_ovf_full, ovf_q, cnt_q == NameMax, "truncated name not full")
  `CFP_ASSERT_IMP(a_no_value_in_name, dcnt_q == 8'd0, (acc_q == 32'd0) && !neg_q,
    "value accumulated before first delimiter")
  `CFP_ASSERT_NXT(a_ctrl_clears, step_i && is_ctrl, (cnt_q == '0) && (dcnt_q == 8'd0),
    "control byte did not clear the line")

endmodule

// ===== sv/cfp_out_stage.sv =====
// result register toward the output stream
`timescale 1ns / 1ps
module cfp_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic             rec_valid_i,
  input  cfp_pkg::record_t rec_i,
  output logic             space_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cfp_pkg::record_t rec_o
);

  logic             valid_q, valid_d;
  cfp_pkg::record_t rec_q;

  // room for a new word when empty or when the held word leaves now
  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = rec_valid_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i && rec_valid_i) begin
      rec_q <= rec_i;
    end
  end

  assign out_valid_o = valid_q;
  assign rec_o       = rec_q;

endmodule

// ===== sv/command_field_parser.sv =====
// top level of the command field parser
//
//   port group   dir  word contents (lowest bit first)
//   s_axis       in   tdata[7:0] rx_byte
//   m_axis       out  tdata: name_chars[63:0], name_length[67:64],
//                     name_truncated[68], field_index[76:69], field_value[108:77]
//   cfg          in   index 0 delimiter_char, index 1 reader_enabled
//
// one byte per cycle sustained while m_axis is ready; a record is valid on m_axis once
// its byte has passed the input register, then the result register
// the parser state updates once per byte in a single pass of logic
// a stalled m_axis holds one record while one more byte waits in the
// input register; after that s_axis_tready drops
// reset is asynchronous and clears the line state and the control registers, not the payload
`timescale 1ns / 1ps
`include "command_field_parser_macros.svh"
module command_field_parser #(
  parameter int unsigned MAX_NAME = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // rx_byte
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [cfp_pkg::TdataOutW-1:0] m_axis_tdata, // name_chars, name_length,
                                                      // name_truncated, field_index,
                                                      // field_value, zero pad
  // configuration writes
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [7:0]   cfg_data_i
);

  cfp_pkg::cfg_t    cfg_q;
  cfp_pkg::record_t rec, rec_out;
  logic             byte_valid, space, advance, rec_valid;
  logic [7:0]       in_byte;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delimiter_char <= cfp_pkg::DelimReset;
      cfg_q.reader_enabled <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cfp_pkg::RegDelimiter: cfg_q.delimiter_char <= cfg_data_i;
        cfp_pkg::RegReaderEn:  cfg_q.reader_enabled <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // a held byte is parsed when the result register has room
  assign advance = byte_valid && space;

  cfp_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .advance_i   (advance),
    .byte_valid_o(byte_valid),
    .byte_o      (in_byte)
  );

  cfp_parser #(.MAX_NAME(MAX_NAME)) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .step_i     (advance),
    .byte_i     (in_byte),
    .rec_valid_o(rec_valid),
    .rec_o      (rec)
  );

  cfp_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .rec_valid_i(rec_valid),
    .rec_i      (rec),
    .space_o    (space),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .rec_o      (rec_out)
  );

  // pack the record, first field lowest
  assign m_axis_tdata = {3'b000, rec_out.field_value, rec_out.field_index,
                         rec_out.name_truncated, rec_out.name_length, rec_out.name_chars};

  `CFP_ASSERT_IMP(a_rec_needs_en, rec_valid, cfg_q.reader_enabled,
    "record while reader disabled")
  `CFP_ASSERT_IMP(a_out_len, m_axis_tvalid, (rec_out.name_length != 4'd0) &&
    (rec_out.name_length <= 4'(MAX_NAME)), "record name length out of range")
  `CFP_ASSERT_NXT(a_stall_keeps, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "stalled record changed")

endmodule

// ===== test/tb_command_field_parser.sv =====
// testbench for the command field parser: byte lines in, field records out
`timescale 1ns / 1ps
module tb_command_field_parser;

  localparam int unsigned NameMax = 8;
  localparam logic [7:0] CharLf   = 8'h0A;
  localparam logic [7:0] CharCr   = 8'h0D;
  localparam logic [7:0] CharSemi = 8'h3B;
  localparam logic [7:0] CharFive = 8'h35;
  localparam int unsigned RandomBytes = 100;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;   // rx_byte
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [cfp_pkg::TdataOutW-1:0] m_axis_tdata; // name_chars, name_length,
                                               // name_truncated, field_index,
                                               // field_value, zero pad
  logic         cfg_we_i = 1'b0;
  logic         cfg_index_i = 1'b0;
  logic [7:0]   cfg_data_i = '0;

  // parser state mirrored on the bench side
  cfp_pkg::cfg_t    parser_cfg;
  logic [63:0]      name_store;
  logic [3:0]       name_count;
  logic             name_overflow;
  logic [7:0]       delim_count;
  logic [31:0]      value_acc;
  logic             sign_neg;
  cfp_pkg::record_t pending_records[$];

  int unsigned error_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned line_count = 0;
  int unsigned records_checked = 0;
  int unsigned sink_wait = 0;
  bit          steady_flow = 1'b0;

  command_field_parser #(
    .MAX_NAME(NameMax)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // print one mismatch line and count it
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= 30) begin
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    end
  endtask

  // line parser prediction for one accepted byte
  task automatic parse_byte(input logic [7:0] c);
    logic             is_delim;
    logic             is_ctrl;
    cfp_pkg::record_t rec;
    is_delim = (c == parser_cfg.delimiter_char);
    is_ctrl  = (c < cfp_pkg::CtrlLimit) || (c == cfp_pkg::CharDel);
    if (delim_count != 0 && c >= cfp_pkg::CharZero && c <= cfp_pkg::CharNine) begin
      value_acc = value_acc * 32'd10 + 32'(c - cfp_pkg::CharZero);
    end else if (delim_count != 0 && c == cfp_pkg::CharMinus) begin
      sign_neg = ~sign_neg;
    end else if (is_delim || is_ctrl) begin
      if (parser_cfg.reader_enabled && name_count != 0) begin
        rec.name_chars     = name_store;
        rec.name_length    = name_count;
        rec.name_truncated = name_overflow;
        rec.field_index    = delim_count;
        rec.field_value    = sign_neg ? 32'd0 - value_acc : value_acc;
        pending_records.push_back(rec);
      end
      value_acc = '0;
      sign_neg  = 1'b0;
    end else if (delim_count == 0) begin
      if (name_count < NameMax) begin
        name_store[8*name_count +: 8] = c;
        name_count++;
      end else begin
        name_overflow = 1'b1;
      end
    end
    if (is_delim && delim_count != cfp_pkg::IndexMax) delim_count++;
    // control byte ends the line
    if (is_ctrl) begin
      name_store    = '0;
      name_count    = '0;
      name_overflow = 1'b0;
      delim_count   = '0;
    end
  endtask

  // send one byte after a random gap, predict on acceptance
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // let every pending record drain, then the pipeline settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == cfp_pkg::RegDelimiter) parser_cfg.delimiter_char = data;
    else parser_cfg.reader_enabled = data[0];
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_name_char();
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                      : 8'($urandom_range(32, 126));
    end while (c == parser_cfg.delimiter_char);
    return c;
  endfunction

  function automatic logic [7:0] pick_line_end();
    case ($urandom_range(0, 3))
      0:       return CharLf;
      1:       return CharCr;
      2:       return cfp_pkg::CharDel;
      default: return 8'($urandom_range(0, 31));
    endcase
  endfunction

  // name, a few delimited numeric fields, control byte
  task automatic send_random_line();
    int unsigned name_len;
    int unsigned n_fields;
    int unsigned n_digits;
    steady_flow = ($urandom_range(0, 4) == 0);
    name_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 8);
    repeat (name_len) send_byte(pick_name_char());
    n_fields = $urandom_range(0, 5);
    repeat (n_fields) begin
      send_byte(parser_cfg.delimiter_char);
      repeat ($urandom_range(0, 2)) send_byte(cfp_pkg::CharMinus);
      n_digits = $urandom_range(0, 12);
      repeat (n_digits) begin
        if ($urandom_range(0, 15) == 0) send_byte(8'($urandom_range(32, 126)));
        else send_byte(8'(cfp_pkg::CharZero + $urandom_range(0, 9)));
      end
    end
    send_byte(pick_line_end());
    line_count++;
  endtask

  task automatic send_noise();
    steady_flow = ($urandom_range(0, 2) == 0);
    repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
  endtask

  // reset defaults: comma delimiter, records held back
  task automatic test_reader_off();
    send_text("AB,12");
    send_byte(CharLf);
    line_count++;
  endtask

  // truncated name with digits and high bytes, sign flips, ignored chars,
  // empty names, lone control bytes
  task automatic test_directed_lines();
    wait_idle();
    write_reg(cfp_pkg::RegReaderEn, 8'h01);
    send_text("Q-9");
    send_byte(8'h80);
    send_byte(8'hFF);
    send_text("abcd");
    send_text(",--7x3");
    send_byte(CharLf);
    send_text(",5");
    send_byte(cfp_pkg::CharDel);
    send_text("Z,-");
    send_byte(8'h00);
    send_byte(8'h1F);
    line_count += 4;
  endtask

  // field index stops at its maximum
  task automatic test_index_saturation();
    steady_flow = 1'b0;
    send_text("SAT");
    repeat (260) begin
      if ($urandom_range(0, 9) == 0) send_byte(8'(cfp_pkg::CharZero + $urandom_range(0, 9)));
      send_byte(parser_cfg.delimiter_char);
    end
    send_byte(CharLf);
    line_count++;
  endtask

  // delimiter as control byte, high byte, digit, minus and ordinary chars
  task automatic test_delimiter_settings();
    logic [7:0] delim_set[6];
    delim_set = '{8'h00, 8'hFF, CharFive, cfp_pkg::CharMinus, CharSemi,
                  cfp_pkg::DelimReset};
    foreach (delim_set[k]) begin
      wait_idle();
      write_reg(cfp_pkg::RegDelimiter, delim_set[k]);
      repeat (2) send_random_line();
    end
  endtask

  // mostly well formed lines, some noise, one stretch with records held back
  task automatic test_random_traffic();
    int unsigned start;
    bit          paused;
    start  = bytes_sent;
    paused = 1'b0;
    while (bytes_sent < start + RandomBytes) begin
      if (!paused && bytes_sent > start + RandomBytes / 2) begin
        paused = 1'b1;
        wait_idle();
        write_reg(cfp_pkg::RegReaderEn, 8'h00);
        repeat (3) send_random_line();
        wait_idle();
        write_reg(cfp_pkg::RegReaderEn, 8'hFF);
      end
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_random_line();
    end
  endtask

  // result check and sink stalls
  always @(posedge clk_i) begin
    cfp_pkg::record_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_records.size() == 0) begin
        report_mismatch("unexpected record", m_axis_tdata[63:0], '0);
      end else begin
        want = pending_records.pop_front();
        if (m_axis_tdata[63:0] !== want.name_chars)
          report_mismatch("name_chars", m_axis_tdata[63:0], want.name_chars);
        if (m_axis_tdata[67:64] !== want.name_length)
          report_mismatch("name_length", 64'(m_axis_tdata[67:64]),
                          64'(want.name_length));
        if (m_axis_tdata[68] !== want.name_truncated)
          report_mismatch("name_truncated", 64'(m_axis_tdata[68]),
                          64'(want.name_truncated));
        if (m_axis_tdata[76:69] !== want.field_index)
          report_mismatch("field_index", 64'(m_axis_tdata[76:69]),
                          64'(want.field_index));
        if (m_axis_tdata[108:77] !== want.field_value)
          report_mismatch("field_value", 64'(m_axis_tdata[108:77]),
                          64'($unsigned(want.field_value)));
        if (m_axis_tdata[cfp_pkg::TdataOutW-1:109] !== '0)
          report_mismatch("pad bits", 64'(m_axis_tdata[cfp_pkg::TdataOutW-1:109]), '0);
        records_checked++;
      end
      sink_wait = steady_flow ? 0 : $urandom_range(0, 8);
    end
    if (sink_wait != 0) begin
      sink_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // bench-side state after reset
  initial begin
    parser_cfg.delimiter_char = cfp_pkg::DelimReset;
    parser_cfg.reader_enabled = 1'b0;
    name_store    = '0;
    name_count    = '0;
    name_overflow = 1'b0;
    delim_count   = '0;
    value_acc     = '0;
    sign_neg      = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reader_off();
    test_directed_lines();
    test_index_saturation();
    test_delimiter_settings();
    test_random_traffic();
    wait_idle();
    $display("sent %0d bytes in %0d lines plus noise, checked %0d records",
             bytes_sent, line_count, records_checked);
    $display("delimiters covered: control, 0xff, digit, minus, ';', ','; %0d mismatches",
             error_count);
    if (error_count == 0) begin
      $display("tb_command_field_parser OK");
    end else begin
      $display("tb_command_field_parser NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("timeout with %0d records outstanding", pending_records.size());
    $display("tb_command_field_parser NOT OK");
    $finish;
  end

endmodule
